// File: src/binary_to_decimal_digits_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary-to-decimal digit converter.
// Each macro expects clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_DIGITS_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_DIGITS_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define B2DD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define B2DD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/b2dd_pkg.sv
// ----------------------------------------------------------------------------
// b2dd_pkg
// Shared widths, constants and controller/datapath interface types for the
// binary-to-decimal digit converter.
// ----------------------------------------------------------------------------
package b2dd_pkg;

    localparam int BIN_W          = 64;
    localparam int NUM_DIGITS     = 20;
    localparam int BCD_W          = NUM_DIGITS * 4;
    localparam int CNT_W          = $clog2(NUM_DIGITS + 1);
    localparam int SHIFT_W        = $clog2(BIN_W);
    localparam int CHAR_W         = 6;
    localparam int MAX_DIGITS_DEF = 20;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // take a new value, clear the digit register
        logic shift;       // one double-dabble step
        logic trim;        // drop a leading zero digit
        logic emit_digit;  // move the top digit into the output register
        logic emit_ovf;    // load an overflow result into the output register
    } b2dd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic top_zero;    // most significant remaining digit is zero
        logic ndig_one;    // exactly one digit remains
        logic too_many;    // remaining digit count exceeds the limit
        logic out_free;    // output register can take a result this cycle
    } b2dd_stat_t;

endpackage

// File: src/b2dd_ctrl.sv
// ----------------------------------------------------------------------------
// b2dd_ctrl
// Sequencer for the converter: accept, 64 double-dabble steps, leading zero
// trim, then digit or overflow emission paced by the output register.
// ----------------------------------------------------------------------------
module b2dd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  b2dd_pkg::b2dd_stat_t stat,
    output b2dd_pkg::b2dd_cmd_t  cmd
);
    import b2dd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_TRIM,
        ST_EMIT,
        ST_OVF
    } state_t;

    localparam logic [SHIFT_W-1:0] SHIFT_LAST = SHIFT_W'(BIN_W - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [SHIFT_W-1:0] cnt_reg;
    logic [SHIFT_W-1:0] cnt_next;

    // Take a new transaction only when idle
    assign in_stall = (state_reg != ST_IDLE);

    // Decode next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + SHIFT_W'(1);
                if (cnt_reg == SHIFT_LAST)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if (stat.top_zero && !stat.ndig_one)
                begin
                    cmd.trim = 1'b1;
                end
                else if (stat.too_many)
                begin
                    state_next = ST_OVF;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (stat.ndig_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OVF:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_ovf = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: src/b2dd_datapath.sv
// ----------------------------------------------------------------------------
// b2dd_datapath
// Binary shift register, 20-digit BCD register with add-3 correction,
// remaining digit count, and the registered output stage.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_digits_top_assert.svh"

module b2dd_datapath
#(
    parameter int MAX_DIGITS = b2dd_pkg::MAX_DIGITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [b2dd_pkg::BIN_W-1:0]    value,
    input  b2dd_pkg::b2dd_cmd_t           cmd,
    output b2dd_pkg::b2dd_stat_t          stat,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [b2dd_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last,
    output logic                          overflow
);
    import b2dd_pkg::*;

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_DIGITS);

    logic [BIN_W-1:0]  bin_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic [CNT_W-1:0]  ndig_reg;
    logic [BCD_W-1:0]  adj;
    logic [3:0]        top_digit;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] digit_char_reg;
    logic              last_reg;
    logic              overflow_reg;

    // Add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // Report status to the controller
    always_comb
    begin
        stat.top_zero = (top_digit == 4'd0);
        stat.ndig_one = (ndig_reg == CNT_W'(1));
        stat.too_many = (ndig_reg > LIMIT);
        stat.out_free = !out_valid_reg || !out_stall;
    end

    // Load, convert, and drop digits off the top
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg  <= value;
            bcd_reg  <= '0;
            ndig_reg <= CNT_W'(NUM_DIGITS);
        end
        else if (cmd.shift)
        begin
            bin_reg <= {bin_reg[BIN_W-2:0], 1'b0};
            bcd_reg <= {adj[BCD_W-2:0], bin_reg[BIN_W-1]};
        end
        else if (cmd.trim || cmd.emit_digit)
        begin
            bcd_reg  <= {bcd_reg[BCD_W-5:0], 4'd0};
            ndig_reg <= ndig_reg - CNT_W'(1);
        end
    end

    // Track output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_digit || cmd.emit_ovf)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_digit)
        begin
            digit_char_reg <= ASCII_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
            last_reg       <= stat.ndig_one;
            overflow_reg   <= 1'b0;
        end
        else if (cmd.emit_ovf)
        begin
            digit_char_reg <= ASCII_ZERO;
            last_reg       <= 1'b1;
            overflow_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last       = last_reg;
    assign overflow   = overflow_reg;

    // Check controller/datapath agreement and result shape
    `B2DD_ASSERT_NOW(a_trim_leading_zero, cmd.trim, stat.top_zero && !stat.ndig_one, "trim of a nonzero or sole digit")
    `B2DD_ASSERT_NOW(a_emit_free, cmd.emit_digit || cmd.emit_ovf, stat.out_free, "result loaded over a pending result")
    `B2DD_ASSERT_NOW(a_ovf_is_last, out_valid_reg && overflow_reg, last_reg && (digit_char_reg == ASCII_ZERO), "overflow result malformed")
    `B2DD_ASSERT_NOW(a_digit_range, out_valid_reg && !overflow_reg, (digit_char_reg >= ASCII_ZERO) && (digit_char_reg <= ASCII_NINE), "digit outside zero to nine")

endmodule

// File: src/binary_to_decimal_digits_top.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_digits_top
// Converts an unsigned 64-bit value to decimal ASCII digits, most significant
// first, leading zeros suppressed.
//
// Input channel: in_valid / in_stall carry value. One transaction is worked
// on at a time; in_stall is high from acceptance until the last result has
// been loaded into the output register.
// Output channel: out_valid / out_stall carry digit_char, last, overflow.
// One result per digit; last marks the final digit. A value with more than
// MAX_DIGITS digits gives one result with overflow and last set, digit '0'.
// Sequence: double-dabble shifting, leading zero trim of the 20-n zero
// digits of an n-digit value, a decision step, then one digit per cycle
// while the output register is free to take it.
// A stalled output register holds its result and pauses digit emission;
// the next value may be accepted while the final result still waits.
// Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module binary_to_decimal_digits_top
#(
    parameter int MAX_DIGITS = b2dd_pkg::MAX_DIGITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [b2dd_pkg::BIN_W-1:0]    value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [b2dd_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last,
    output logic                          overflow
);
    import b2dd_pkg::*;

    b2dd_cmd_t  cmd;
    b2dd_stat_t stat;

    // Sequencer
    b2dd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Conversion and output datapath
    b2dd_datapath
    #(
        .MAX_DIGITS (MAX_DIGITS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last),
        .overflow   (overflow)
    );

endmodule

// File: verif/binary_to_decimal_digits_top_tb.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_digits_top_tb
// Self-checking bench for the 64-bit binary to decimal ASCII digit converter.
// A queue of values (directed corner values, then random values of every
// length) feeds a clocked driver. Each accepted value is expanded here into
// its expected digit stream. A clocked monitor checks every output
// transaction against the oldest expected digit. Both sides idle at random,
// and the receiver holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module binary_to_decimal_digits_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import b2dd_pkg::*;

    localparam int LIMIT_DIGITS = MAX_DIGITS_DEF;
    localparam int RANDOM_VALUES = 260;
    localparam int LONG_HOLD = 400;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              ovf;
    } digit_rec_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [BIN_W-1:0]    value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [CHAR_W-1:0]   digit_char;
    logic                last;
    logic                overflow;

    logic [BIN_W-1:0] values_to_send[$];
    digit_rec_t       digits_due[$];
    int               mismatches = 0;
    int               results_seen = 0;
    int               in_gap = 0;
    int               out_wait = 0;
    bit               in_calm = 1'b0;
    bit               out_calm = 1'b0;
    logic             hold_off = 1'b0;

    binary_to_decimal_digits_top #(.MAX_DIGITS(LIMIT_DIGITS)) uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last),
        .overflow   (overflow)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Expand one value into its decimal digits, most significant first
    function automatic void queue_decimal_digits(input logic [BIN_W-1:0] v);
        logic [3:0]       rev[NUM_DIGITS];
        logic [BIN_W-1:0] rest;
        int               count;
        int               k;
        digit_rec_t       d;
        rest = v;
        count = 0;
        do
        begin
            rev[count] = 4'(rest % 64'd10);
            rest = rest / 64'd10;
            count++;
        end
        while (rest != '0 && count < NUM_DIGITS);
        if (count > LIMIT_DIGITS)
        begin
            d.ch = ASCII_ZERO;
            d.last = 1'b1;
            d.ovf = 1'b1;
            digits_due.push_back(d);
        end
        else
        begin
            for (k = 0; k < count; k++)
            begin
                d.ch = ASCII_ZERO + CHAR_W'(rev[count - 1 - k]);
                d.last = (k == count - 1);
                d.ovf = 1'b0;
                digits_due.push_back(d);
            end
        end
    endfunction

    // Idle cycles before the next transaction; calm stretches have none
    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // Driver: offer queued values, hold payload while stalled
    always @(posedge clk or negedge rst_n)
    begin : driver
        int g;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value <= '0;
            in_gap <= 0;
        end
        else if (in_valid && !in_stall)
        begin
            queue_decimal_digits(value);
            if ($urandom_range(0, 15) == 0)
                in_calm = !in_calm;
            g = draw_gap(in_calm);
            if (g == 0 && values_to_send.size() != 0)
            begin
                value <= values_to_send.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
                in_gap <= g;
            end
        end
        else if (!in_valid)
        begin
            if (in_gap > 0)
                in_gap <= in_gap - 1;
            else if (values_to_send.size() != 0)
            begin
                in_valid <= 1'b1;
                value <= values_to_send.pop_front();
            end
        end
    end

    // Monitor: check each output transaction, then draw the next stall
    always @(posedge clk or negedge rst_n)
    begin : monitor
        int         wait_n;
        digit_rec_t exp_d;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_wait <= 0;
        end
        else
        begin
            wait_n = out_wait;
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (digits_due.size() == 0)
                begin
                    $error("unexpected result: digit_char=%0d last=%0b overflow=%0b",
                           digit_char, last, overflow);
                    mismatches++;
                end
                else
                begin
                    exp_d = digits_due.pop_front();
                    if (digit_char !== exp_d.ch)
                    begin
                        $error("digit_char: expected %0d, got %0d", exp_d.ch, digit_char);
                        mismatches++;
                    end
                    if (last !== exp_d.last)
                    begin
                        $error("last: expected %0b, got %0b", exp_d.last, last);
                        mismatches++;
                    end
                    if (overflow !== exp_d.ovf)
                    begin
                        $error("overflow: expected %0b, got %0b", exp_d.ovf, overflow);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    out_calm = !out_calm;
                wait_n = draw_gap(out_calm);
            end
            if (hold_off || wait_n > 0)
            begin
                out_stall <= 1'b1;
                out_wait <= (wait_n > 0) ? wait_n - 1 : 0;
            end
            else
            begin
                out_stall <= 1'b0;
                out_wait <= 0;
            end
        end
    end

    // Hold the output off once for a long stretch so the input backs up
    initial
    begin
        while (results_seen < 60)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Stimulus, reset and end of run
    initial
    begin : stimulus
        logic [BIN_W-1:0] v;
        logic [BIN_W-1:0] p;
        int               i;
        int               k;

        // corner values: digit count boundaries, extremes, bit patterns
        values_to_send.push_back(64'd0);
        values_to_send.push_back(64'd1);
        values_to_send.push_back(64'd9);
        values_to_send.push_back(64'd10);
        values_to_send.push_back(64'd99);
        values_to_send.push_back(64'd100);
        values_to_send.push_back(64'd1234567890);
        values_to_send.push_back(64'h0000_0000_FFFF_FFFF);
        values_to_send.push_back(64'h0000_0001_0000_0000);
        values_to_send.push_back(64'd999999999999999999);
        values_to_send.push_back(64'd1000000000000000000);
        values_to_send.push_back(64'd9999999999999999999);
        values_to_send.push_back(64'd10000000000000000000);
        values_to_send.push_back(64'h8000_0000_0000_0000);
        values_to_send.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        values_to_send.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        values_to_send.push_back(64'hFFFF_FFFF_FFFF_FFFE);
        values_to_send.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        values_to_send.push_back(64'h5555_5555_5555_5555);
        values_to_send.push_back(64'd10203040506070809);

        // random values of every length, plus values around powers of ten
        for (i = 0; i < RANDOM_VALUES; i++)
        begin
            v = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0:
                begin
                    p = 64'd1;
                    for (k = $urandom_range(0, 19); k > 0; k--)
                        p = p * 64'd10;
                    v = p - BIN_W'($urandom_range(0, 1));
                end
                1:
                begin
                    // keep the full width for 20-digit values
                end
                default:
                begin
                    v = v >> $urandom_range(0, 63);
                end
            endcase
            values_to_send.push_back(v);
        end

        // hold reset, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // drain: all values accepted, all digits seen, then a latency tail
        while (values_to_send.size() != 0 || in_valid)
            @(posedge clk);
        while (digits_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(10_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/b2dd_pkg.sv
src/b2dd_ctrl.sv
src/b2dd_datapath.sv
src/binary_to_decimal_digits_top.sv
verif/binary_to_decimal_digits_top_tb.sv
